// ===== rtl/kss_pkg.sv =====
// ---------------------------------------------------------------------------
// Keypad stepper sequencer package
// Shared item types, register map and field widths.
// ---------------------------------------------------------------------------
package kss_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [0:0] REG_STEP_TICKS = 1'd0;

	localparam logic [1:0] STAGE_IDLE  = 2'd0;
	localparam logic [1:0] STAGE_TENS  = 2'd1;
	localparam logic [1:0] STAGE_UNITS = 2'd2;
	localparam logic [1:0] STAGE_RUN   = 2'd3;

	typedef struct packed {
		logic       command;
		logic [1:0] key_row;
		logic [1:0] key_col;
	} in_item_t;

	typedef struct packed {
		logic [7:0] port_a;
		logic [7:0] port_b;
		logic [1:0] stage;
		logic [3:0] motion;
		logic [6:0] distance;
		logic       finished;
		logic       aborted;
	} out_item_t;

endpackage

// ===== rtl/keypad_stepper_sequencer.sv =====
// ---------------------------------------------------------------------------
// Keypad stepper sequencer
// Wave-drive sequencer for four stepper motors, controlled by keypad and
// tick items.
// ---------------------------------------------------------------------------
//  Channel  Signals                       Direction  Content
//  in       in_valid/in_ready/in_item     into       tick or key press
//  out      out_valid/out_ready/out_item  out of     ports, stage, status
//  cfg      psel/penable/pwrite/paddr...  into       step_ticks at 0x0
//
// One item is taken every cycle while the result is not stalled; its
// result passes the input register and then the result register.
// The state update is combinational between those registers.
// Reset is asynchronous; step_ticks resets to 1 and all state to idle.
// While out_ready is low the result holds and one further item waits in
// the input register.
// ---------------------------------------------------------------------------
module keypad_stepper_sequencer
	import kss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   result_q;
	out_item_t   result;
	logic        advance;
	logic [15:0] step_ticks;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = result_q;

	kss_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.step_ticks (step_ticks)
	);

	kss_seq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.step_ticks (step_ticks),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			result_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_abort_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.aborted |-> result_q.finished)
		else $error("aborted item without finished");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.finished |-> result_q.stage == STAGE_IDLE)
		else $error("finished item not idle");

	a_ports_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.stage != STAGE_RUN
		|-> result_q.port_a == 8'd0 && result_q.port_b == 8'd0)
		else $error("ports driven outside a run");

	a_one_coil: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.stage == STAGE_RUN
		|-> $onehot({result_q.port_a, result_q.port_b}))
		else $error("run drives other than one coil");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(result_q))
		else $error("stalled result changed");
`endif

endmodule

// ===== rtl/kss_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the phase hold time in ticks.
// ---------------------------------------------------------------------------
module kss_cfg_regs
	import kss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [15:0]           step_ticks
);

	logic [15:0] step_ticks_q;
	logic        sel_step;

	assign sel_step   = (paddr[2] == REG_STEP_TICKS);
	assign pready     = 1'b1;
	assign step_ticks = step_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= 16'd1;
		end else if (psel && penable && pwrite && sel_step) begin
			step_ticks_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_step) begin
			prdata = {16'd0, step_ticks_q};
		end
	end

endmodule

// ===== rtl/kss_seq_core.sv =====
// ---------------------------------------------------------------------------
// Sequencer core
// Key decoding, entry state machine, phase and rotation counting and the
// wave-drive pattern for one item.
// ---------------------------------------------------------------------------
module kss_seq_core
	import kss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  in_item_t    item,
	input  logic [15:0] step_ticks,
	output out_item_t   result
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_TENS  = 2'd1,
		ST_UNITS = 2'd2,
		ST_RUN   = 2'd3
	} state_t;

	state_t      state_q, state_n;
	logic [2:0]  motion_q, motion_n;
	logic [3:0]  tens_q, tens_n;
	logic [6:0]  distance_q, distance_n;
	logic [1:0]  phase_q, phase_n;
	logic [6:0]  rotation_q, rotation_n;
	logic [15:0] tick_q, tick_n;

	logic        key_ok;
	logic [3:0]  key_val;
	logic        is_key;
	logic [15:0] limit;
	logic [16:0] held;
	logic        fin, abt;
	logic [3:0]  nib;
	logic [7:0]  pat;

	assign is_key = item.command;
	assign limit  = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
	assign held   = {1'b0, tick_q} + 17'd1;

	always_comb begin
		key_ok  = 1'b0;
		key_val = 4'd0;
		if (item.key_row != 2'd3 && item.key_col != 2'd3) begin
			key_ok  = 1'b1;
			key_val = 4'({item.key_row, 1'b0}) + 4'(item.key_row)
				+ 4'(item.key_col) + 4'd1;
		end else if (item.key_row == 2'd3 && item.key_col == 2'd1) begin
			key_ok  = 1'b1;
			key_val = 4'd0;
		end
	end

	always_comb begin
		state_n    = state_q;
		motion_n   = motion_q;
		tens_n     = tens_q;
		distance_n = distance_q;
		phase_n    = phase_q;
		rotation_n = rotation_q;
		tick_n     = tick_q;
		fin        = 1'b0;
		abt        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_key && key_ok && key_val >= 4'd1 && key_val <= 4'd8) begin
					motion_n = 3'(key_val - 4'd1);
					state_n  = ST_TENS;
				end
			end
			ST_TENS: begin
				if (is_key && key_ok) begin
					tens_n  = key_val;
					state_n = ST_UNITS;
				end
			end
			ST_UNITS: begin
				if (is_key && key_ok) begin
					distance_n = 7'({tens_q, 3'b000}) + 7'({tens_q, 1'b0})
						+ 7'(key_val);
					phase_n    = 2'd0;
					rotation_n = 7'd0;
					tick_n     = 16'd0;
					state_n    = ST_RUN;
				end
			end
			ST_RUN: begin
				if (is_key) begin
					if (key_ok && key_val == 4'd9) begin
						state_n = ST_IDLE;
						fin     = 1'b1;
						abt     = 1'b1;
					end
				end else if (held >= {1'b0, limit}) begin
					tick_n = 16'd0;
					if (phase_q == 2'd3) begin
						phase_n = 2'd0;
						if (rotation_q >= distance_q) begin
							state_n = ST_IDLE;
							fin     = 1'b1;
						end else begin
							rotation_n = rotation_q + 7'd1;
						end
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end else begin
					tick_n = held[15:0];
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		nib = motion_n[0] ? (4'b1000 >> phase_n) : (4'b0001 << phase_n);
		pat = motion_n[1] ? {nib, 4'b0000} : {4'b0000, nib};
		result.port_a   = 8'd0;
		result.port_b   = 8'd0;
		if (state_n == ST_RUN) begin
			if (motion_n[2]) begin
				result.port_b = pat;
			end else begin
				result.port_a = pat;
			end
		end
		result.stage    = 2'(state_n);
		result.motion   = (state_n == ST_IDLE) ? 4'd0 : {1'b0, motion_n} + 4'd1;
		result.distance = distance_n;
		result.finished = fin;
		result.aborted  = abt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			motion_q   <= 3'd0;
			tens_q     <= 4'd0;
			distance_q <= 7'd0;
			phase_q    <= 2'd0;
			rotation_q <= 7'd0;
			tick_q     <= 16'd0;
		end else if (advance) begin
			state_q    <= state_n;
			motion_q   <= motion_n;
			tens_q     <= tens_n;
			distance_q <= distance_n;
			phase_q    <= phase_n;
			rotation_q <= rotation_n;
			tick_q     <= tick_n;
		end
	end

endmodule
